FILE: sv/nnt_pkg.sv
// Shared constants and types for the nearest-neighbor tour block.
// No dependencies; imported by nearest_neighbor_tour.
package nnt_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_WIDTH = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int DIST_W      = 2 * COORD_WIDTH + 1;
    localparam int IN_DATA_W   = 2 * COORD_WIDTH;
    localparam int OUT_FIELD_W = IDX_W + 2 * COORD_WIDTH;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [IDX_W-1:0]              t_idx;
    typedef logic [CNT_W-1:0]              t_cnt;
    typedef logic [DIST_W-1:0]             t_dist;

endpackage

FILE: sv/nearest_neighbor_tour.sv
// Nearest-neighbor tour builder: point store, visited map and a sequencer
// around one shared multiplier. Depends on nnt_pkg.
//   Slave channel: one beat per point, tdata = {y, x}, tlast marks the last
//   point of a batch. Points load at one beat per cycle while idle. A point
//   that arrives with the store full (MAX_POINTS entries) is dropped and the
//   batch is flagged; a dropped last point still starts the tour.
//   Master channel: after the last point the block emits every stored point
//   index in tour order, starting at point 0 and moving each time to the
//   nearest unvisited point (squared distance, ties to the lowest index).
//   tlast marks the final beat of the tour, tuser repeats the drop flag.
//   Sequence: after the last point, point 0 is read, captured and emitted
//   through the output register. Each step scans all n stored points; an
//   unvisited candidate goes through store read, difference, two multiplier
//   passes and compare, a visited one is passed over; each step ends with
//   end of scan, advance, emit. The slave side is not ready while a tour runs.
//   Stall: results go through an output register; the sequencer holds before
//   overwriting it. The last result may wait there while the next batch loads.
//   Reset: synchronous, active low; clears the count, the drop flag, the
//   visited map and the output valid flag. Store contents stay undefined.
module nearest_neighbor_tour (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: [15:0] x_coord, [31:16] y_coord
    input  logic [nnt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: [5:0] point_index, [21:6] out_x, [37:22] out_y, rest zero
    output logic [nnt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,
    // tuser: [0] dropped_points
    output logic                              m_axis_tuser
);
    import nnt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_CAP0 = 4'd2;
    localparam logic [3:0] S_EMIT = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_DIFF = 4'd5;
    localparam logic [3:0] S_SQX  = 4'd6;
    localparam logic [3:0] S_SQY  = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_NEXT = 4'd9;

    // point store, one registered read port
    t_coord x_store [MAX_POINTS];
    t_coord y_store [MAX_POINTS];
    t_coord r_rd_x, r_rd_y;

    logic [3:0]            r_state;
    t_cnt                  r_count;
    logic                  r_ovf;
    logic [MAX_POINTS-1:0] r_visited;
    t_idx                  r_cur;
    t_coord                r_cur_x, r_cur_y;
    t_cnt                  r_idx;
    t_cnt                  r_step;
    logic                  r_found;
    t_idx                  r_best;
    t_coord                r_best_x, r_best_y;
    t_dist                 r_best_d;
    t_coord                r_cx, r_cy;
    logic [COORD_WIDTH-1:0] r_dx, r_dy;
    t_dist                 r_acc;
    t_dist                 r_sum;

    logic                  r_out_valid;
    t_idx                  r_out_idx;
    t_coord                r_out_x, r_out_y;
    logic                  r_out_last, r_out_drop;

    logic                  in_beat, out_beat, out_free, last_step;
    logic                  write_en;
    t_idx                  idx_lo;
    logic signed [COORD_WIDTH:0] diff_x, diff_y;
    logic [COORD_WIDTH:0]  mag_x, mag_y;
    logic [COORD_WIDTH-1:0] mul_op;
    logic [2*COORD_WIDTH-1:0] mul_prod;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = r_out_valid && m_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign last_step     = (r_step + t_cnt'(1)) == r_count;
    assign write_en      = in_beat && (r_count < t_cnt'(MAX_POINTS));
    assign idx_lo        = r_idx[IDX_W-1:0];

    // store write while loading, read at the scan index every cycle
    always_ff @(posedge i_clk) begin
        if (write_en) begin
            x_store[r_count[IDX_W-1:0]] <= s_axis_tdata[COORD_WIDTH-1:0];
            y_store[r_count[IDX_W-1:0]] <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end
        r_rd_x <= x_store[idx_lo];
        r_rd_y <= y_store[idx_lo];
    end

    // absolute coordinate differences against the current point
    assign diff_x = {r_cur_x[COORD_WIDTH-1], r_cur_x} - {r_rd_x[COORD_WIDTH-1], r_rd_x};
    assign diff_y = {r_cur_y[COORD_WIDTH-1], r_cur_y} - {r_rd_y[COORD_WIDTH-1], r_rd_y};
    assign mag_x  = diff_x[COORD_WIDTH] ? (COORD_WIDTH+1)'(0) - diff_x : diff_x;
    assign mag_y  = diff_y[COORD_WIDTH] ? (COORD_WIDTH+1)'(0) - diff_y : diff_y;

    // shared squarer: x pass then y pass
    assign mul_op   = (r_state == S_SQX) ? r_dx : r_dy;
    assign mul_prod = mul_op * mul_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_visited   <= '0;
            r_cur       <= '0;
            r_idx       <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new beat when emitting, drop the flag once taken
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (write_en) begin
                            r_count <= r_count + t_cnt'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_idx   <= '0;
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_CAP0;
                end
                S_CAP0: begin
                    // start the tour at point 0
                    r_cur_x      <= r_rd_x;
                    r_cur_y      <= r_rd_y;
                    r_cur        <= '0;
                    r_visited    <= MAX_POINTS'(1);
                    r_step       <= '0;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_idx   <= r_cur;
                        r_out_x     <= r_cur_x;
                        r_out_y     <= r_cur_y;
                        r_out_last  <= last_step;
                        r_out_drop  <= r_ovf;
                        if (last_step) begin
                            r_count   <= '0;
                            r_ovf     <= 1'b0;
                            r_cur     <= '0;
                            r_visited <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_count) begin
                        r_state <= S_NEXT;
                    end else if (r_visited[idx_lo]) begin
                        r_idx <= r_idx + t_cnt'(1);
                    end else begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_dx    <= mag_x[COORD_WIDTH-1:0];
                    r_dy    <= mag_y[COORD_WIDTH-1:0];
                    r_cx    <= r_rd_x;
                    r_cy    <= r_rd_y;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_acc   <= DIST_W'(mul_prod);
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sum   <= r_acc + DIST_W'(mul_prod);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // strict less keeps the lowest index on ties
                    if (!r_found || (r_sum < r_best_d)) begin
                        r_found  <= 1'b1;
                        r_best_d <= r_sum;
                        r_best   <= idx_lo;
                        r_best_x <= r_cx;
                        r_best_y <= r_cy;
                    end
                    r_idx   <= r_idx + t_cnt'(1);
                    r_state <= S_SCAN;
                end
                S_NEXT: begin
                    // advance to the nearest candidate
                    r_visited[r_best] <= 1'b1;
                    r_cur   <= r_best;
                    r_cur_x <= r_best_x;
                    r_cur_y <= r_best_y;
                    r_step  <= r_step + t_cnt'(1);
                    r_state <= S_EMIT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_y, r_out_x, r_out_idx});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

    // visited map is empty between tours
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_visited == '0))
        else $error("visited map not clear while idle");

    // store fill never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_POINTS))
        else $error("point count beyond capacity");

    // one visited point per emitted step during a scan
    a_visit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($countones(r_visited) == int'(r_step) + 1))
        else $error("visited count out of step with tour");

    // a chosen candidate is always a stored, unvisited point
    a_best_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |-> (r_found && !r_visited[r_best]
                                 && (t_cnt'(r_best) < r_count)))
        else $error("invalid nearest candidate");

endmodule
